// ----- hw/rtl/epm_pkg.sv -----
// Package for the Euler conserved-to-primitive converter.
// Holds request/result structs, internal stage structs, constants and the
// signed saturation helper. No dependencies.
package epm_pkg;

  localparam int GammaW = 18;
  localparam logic [GammaW-1:0] GAMMA_RST = 18'd91750;
  localparam logic [GammaW-1:0] Q_ONE = 18'd65536;
  localparam logic [30:0] MACH_MAX = 31'h7FFF_FFFF;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NONPOS = 1'b1;

  typedef struct packed {
    logic [30:0]        density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic [30:0]        total_energy;
    logic               last_cell;
  } epm_in_t;

  typedef struct packed {
    logic [30:0]        density_out;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] pressure;
    logic [30:0]        mach_number;
    logic               status;
    logic               last_out;
  } epm_out_t;

  // per-cell data carried alongside the front end and first divider
  typedef struct packed {
    logic [30:0] rho;
    logic [30:0] en;
    logic        nx;
    logic        ny;
    logic        last;
  } epm_cell_t;

  // finished fields carried alongside the Mach divider and square root
  typedef struct packed {
    logic [30:0] rho;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] pbits;
    logic        status;
    logic        force_max;
    logic        last;
  } epm_tail_t;

  // sign/magnitude to saturated signed 32-bit
  function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] mag);
    logic [63:0] twos;
    logic [31:0] res;
    twos = ~mag + 64'd1;
    if (neg) begin
      res = (mag >= 64'h8000_0000) ? 32'h8000_0000 : twos[31:0];
    end else begin
      res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/euler_primitive_and_mach.sv -----
// Euler 2D conserved-to-primitive converter with Mach number.
// A result is registered after the 63-bit velocity/energy dividers, the 62-bit
// Mach divider and the 31-bit root.
// Throughput: one request per cycle, busy never asserts; the receiver cannot stall.
// Reset (sync, active low) clears all valid bits and loads gamma with 1.4.
// Depends on epm_pkg, epm_div, epm_sqrt.
module euler_primitive_and_mach
  import epm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  epm_in_t           in_data,
  output logic              out_valid,
  output epm_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GammaW-1:0] cfg_data
);

  logic [GammaW-1:0] gamma_r;
  logic              accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RST;
    end else if (cfg_valid && cfg_ready) begin
      gamma_r <= cfg_data;
    end
  end

  // ---------------- front end: magnitudes, squares, sum ----------------
  logic        s0_vld_r;
  epm_cell_t   s0_cell_r;
  logic [31:0] s0_ax_r, s0_ay_r;
  logic [31:0] mx_c, my_c;

  assign mx_c = in_data.momentum_x;
  assign my_c = in_data.momentum_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
    s0_cell_r.rho  <= in_data.density;
    s0_cell_r.en   <= in_data.total_energy;
    s0_cell_r.nx   <= mx_c[31];
    s0_cell_r.ny   <= my_c[31];
    s0_cell_r.last <= in_data.last_cell;
    s0_ax_r <= mx_c[31] ? (~mx_c + 32'd1) : mx_c;
    s0_ay_r <= my_c[31] ? (~my_c + 32'd1) : my_c;
  end

  logic        s1_vld_r;
  epm_cell_t   s1_cell_r;
  logic [31:0] s1_ax_r, s1_ay_r;
  logic [63:0] s1_sqx_r, s1_sqy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s0_vld_r;
    end
    s1_cell_r <= s0_cell_r;
    s1_ax_r   <= s0_ax_r;
    s1_ay_r   <= s0_ay_r;
    s1_sqx_r  <= 64'(s0_ax_r) * 64'(s0_ax_r);
    s1_sqy_r  <= 64'(s0_ay_r) * 64'(s0_ay_r);
  end

  logic        s2_vld_r;
  epm_cell_t   s2_cell_r;
  logic [31:0] s2_ax_r, s2_ay_r;
  logic [64:0] s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_cell_r <= s1_cell_r;
    s2_ax_r   <= s1_ax_r;
    s2_ay_r   <= s1_ay_r;
    s2_sum_r  <= {1'b0, s1_sqx_r} + {1'b0, s1_sqy_r};
  end

  // ---------------- dividers by density ----------------
  logic [62:0] dvx_quo, dvy_quo, dq_quo;
  logic        dvx_ovf, dvy_ovf, dq_ovf, dq_vld;
  logic        dvx_vld, dvy_vld;
  logic [1:0]  dvx_side, dvy_side;
  epm_cell_t   dq_cell;

  // side: {sign, magnitude is zero}
  epm_div #(.NW(65), .DW(31), .QW(63), .SW(2)) u_div_vx (
    .clk(clk), .rst_n(rst_n), .in_vld(s2_vld_r),
    .in_num({17'd0, s2_ax_r, 16'd0}), .in_den(s2_cell_r.rho),
    .in_side({s2_cell_r.nx, (s2_ax_r == 32'd0)}),
    .out_vld(dvx_vld), .out_quo(dvx_quo), .out_ovf(dvx_ovf), .out_side(dvx_side)
  );

  epm_div #(.NW(65), .DW(31), .QW(63), .SW(2)) u_div_vy (
    .clk(clk), .rst_n(rst_n), .in_vld(s2_vld_r),
    .in_num({17'd0, s2_ay_r, 16'd0}), .in_den(s2_cell_r.rho),
    .in_side({s2_cell_r.ny, (s2_ay_r == 32'd0)}),
    .out_vld(dvy_vld), .out_quo(dvy_quo), .out_ovf(dvy_ovf), .out_side(dvy_side)
  );

  epm_div #(.NW(65), .DW(31), .QW(63), .SW($bits(epm_cell_t))) u_div_q (
    .clk(clk), .rst_n(rst_n), .in_vld(s2_vld_r),
    .in_num(s2_sum_r), .in_den(s2_cell_r.rho), .in_side(s2_cell_r),
    .out_vld(dq_vld), .out_quo(dq_quo), .out_ovf(dq_ovf), .out_side(dq_cell)
  );

  // ---------------- pressure ----------------
  logic [31:0] vx_c, vy_c;
  logic [63:0] q_c;
  logic [62:0] ke_c, en_c, dmag_c;
  logic        dneg_c, gneg_c;
  logic [17:0] gmag_c;

  always_comb begin
    // overflow on the velocity dividers only happens at zero density
    if (dvx_ovf) begin
      vx_c = dvx_side[0] ? 32'd0 : sat_s32(dvx_side[1], 64'h8000_0000);
    end else begin
      vx_c = sat_s32(dvx_side[1], {1'b0, dvx_quo});
    end
    if (dvy_ovf) begin
      vy_c = dvy_side[0] ? 32'd0 : sat_s32(dvy_side[1], 64'h8000_0000);
    end else begin
      vy_c = sat_s32(dvy_side[1], {1'b0, dvy_quo});
    end
    // clamp at 2^63: beyond that pressure and Mach both saturate anyway
    q_c    = dq_ovf ? 64'h8000_0000_0000_0000 : {1'b0, dq_quo};
    ke_c   = q_c[63:1];
    en_c   = {32'd0, dq_cell.en};
    dneg_c = (ke_c > en_c);
    dmag_c = dneg_c ? (ke_c - en_c) : (en_c - ke_c);
    gneg_c = (gamma_r < Q_ONE);
    gmag_c = gneg_c ? (Q_ONE - gamma_r) : (gamma_r - Q_ONE);
  end

  logic        p0_vld_r, p0_dneg_r, p0_gneg_r, p0_last_r;
  logic [31:0] p0_vx_r, p0_vy_r;
  logic [62:0] p0_dmag_r;
  logic [17:0] p0_gmag_r;
  logic [63:0] p0_q_r;
  logic [30:0] p0_rho_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= dq_vld & dvx_vld & dvy_vld;
    end
    p0_vx_r   <= vx_c;
    p0_vy_r   <= vy_c;
    p0_dneg_r <= dneg_c;
    p0_dmag_r <= dmag_c;
    p0_gneg_r <= gneg_c;
    p0_gmag_r <= gmag_c;
    p0_q_r    <= q_c;
    p0_rho_r  <= dq_cell.rho;
    p0_last_r <= dq_cell.last;
  end

  logic        p1_vld_r, p1_pneg_r, p1_zero_r, p1_big_r, p1_last_r;
  logic [31:0] p1_vx_r, p1_vy_r;
  logic [49:0] p1_phi_r;
  logic [33:0] p1_plo_r;
  logic [63:0] p1_q_r;
  logic [30:0] p1_rho_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= p0_vld_r;
    end
    p1_vx_r   <= p0_vx_r;
    p1_vy_r   <= p0_vy_r;
    p1_pneg_r <= p0_dneg_r ^ p0_gneg_r;
    p1_zero_r <= (p0_gmag_r == 18'd0) || (p0_dmag_r == 63'd0);
    p1_big_r  <= (p0_dmag_r[62:48] != 15'd0);
    p1_phi_r  <= 50'(p0_dmag_r[47:16]) * 50'(p0_gmag_r);
    p1_plo_r  <= 34'(p0_dmag_r[15:0]) * 34'(p0_gmag_r);
    p1_q_r    <= p0_q_r;
    p1_rho_r  <= p0_rho_r;
    p1_last_r <= p0_last_r;
  end

  logic [50:0] pmag_c;
  logic        rho0_c;

  always_comb begin
    rho0_c = (p1_rho_r == 31'd0);
    if (p1_zero_r) begin
      pmag_c = '0;
    end else if (p1_big_r) begin
      pmag_c = 51'h2_0000_0000;
    end else begin
      pmag_c = {1'b0, p1_phi_r} + 51'(p1_plo_r[33:16]);
    end
  end

  logic        p2_vld_r, p2_pos_r, p2_last_r;
  logic [31:0] p2_vx_r, p2_vy_r, p2_pbits_r;
  logic [30:0] p2_p_r, p2_rho_r;
  logic [63:0] p2_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_vx_r    <= p1_vx_r;
    p2_vy_r    <= p1_vy_r;
    p2_pbits_r <= rho0_c ? 32'd0 : sat_s32(p1_pneg_r, {13'd0, pmag_c});
    p2_pos_r   <= !rho0_c && !p1_pneg_r && (pmag_c != 51'd0);
    p2_p_r     <= (pmag_c > 51'(MACH_MAX)) ? MACH_MAX : pmag_c[30:0];
    p2_q_r     <= p1_q_r;
    p2_rho_r   <= p1_rho_r;
    p2_last_r  <= p1_last_r;
  end

  // ---------------- Mach: q*2^48 / (gamma*p), then root ----------------
  logic        p3_vld_r;
  logic [48:0] p3_d_r;
  logic [62:0] p3_q_r;
  epm_tail_t   p3_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
    p3_d_r              <= 49'(p2_p_r) * 49'(gamma_r);
    p3_q_r              <= p2_q_r[62:0];
    p3_tail_r.rho       <= p2_rho_r;
    p3_tail_r.vx        <= p2_vx_r;
    p3_tail_r.vy        <= p2_vy_r;
    p3_tail_r.pbits     <= p2_pbits_r;
    p3_tail_r.status    <= p2_pos_r ? STATUS_OK : STATUS_NONPOS;
    p3_tail_r.force_max <= !p2_pos_r || p2_q_r[63];
    p3_tail_r.last      <= p2_last_r;
  end

  logic        md_vld, md_ovf;
  logic [61:0] md_quo;
  epm_tail_t   md_tail, sq_in_tail, sq_tail;
  logic        sq_vld;
  logic [30:0] sq_root;

  // overflow here is q >= d<<14, including zero gamma
  epm_div #(.NW(111), .DW(49), .QW(62), .SW($bits(epm_tail_t))) u_div_mach (
    .clk(clk), .rst_n(rst_n), .in_vld(p3_vld_r),
    .in_num({p3_q_r, 48'd0}), .in_den(p3_d_r), .in_side(p3_tail_r),
    .out_vld(md_vld), .out_quo(md_quo), .out_ovf(md_ovf), .out_side(md_tail)
  );

  always_comb begin
    sq_in_tail = md_tail;
    sq_in_tail.force_max = md_tail.force_max | md_ovf;
  end

  epm_sqrt #(.RW(31), .SW($bits(epm_tail_t))) u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_vld(md_vld), .in_x(md_quo),
    .in_side(sq_in_tail),
    .out_vld(sq_vld), .out_root(sq_root), .out_side(sq_tail)
  );

  // ---------------- result register ----------------
  logic     out_valid_r;
  epm_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_vld;
    end
    out_data_r.density_out <= sq_tail.rho;
    out_data_r.velocity_x  <= sq_tail.vx;
    out_data_r.velocity_y  <= sq_tail.vy;
    out_data_r.pressure    <= sq_tail.pbits;
    out_data_r.mach_number <= sq_tail.force_max ? MACH_MAX : sq_root;
    out_data_r.status      <= sq_tail.status;
    out_data_r.last_out    <= sq_tail.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/epm_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Flags overflow when the quotient does not fit in QW bits. Uses epm_pkg.
module epm_div
  import epm_pkg::*;
#(
  parameter int NW = 65,
  parameter int DW = 31,
  parameter int QW = 63,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic          out_ovf,
  output logic [SW-1:0] out_side
);

  localparam int TW = NW - QW;
  localparam int CW = (TW > DW) ? TW : DW;

  logic          vld_r  [QW+1];
  logic [DW-1:0] rem_r  [QW+1];
  logic [QW-1:0] acc_r  [QW+1];
  logic [DW-1:0] den_r  [QW+1];
  logic          ovf_r  [QW+1];
  logic [SW-1:0] side_r [QW+1];

  logic [CW-1:0] top_c;
  logic [CW-1:0] den_c;

  assign top_c = CW'(in_num[NW-1:QW]);
  assign den_c = CW'(in_den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    ovf_r[0]  <= (top_c >= den_c);
    rem_r[0]  <= DW'(top_c);
    acc_r[0]  <= in_num[QW-1:0];
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1], acc_r[k-1][QW-1]};
    assign ge    = (trial >= {1'b0, den_r[k-1]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      rem_r[k]  <= ge ? DW'(trial - {1'b0, den_r[k-1]}) : trial[DW-1:0];
      acc_r[k]  <= {acc_r[k-1][QW-2:0], ge};
      den_r[k]  <= den_r[k-1];
      ovf_r[k]  <= ovf_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_quo  = acc_r[QW];
  assign out_ovf  = ovf_r[QW];
  assign out_side = side_r[QW];

endmodule

// ----- hw/rtl/epm_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Floor of the root of a 2*RW-bit value, with sideband. Uses epm_pkg.
module epm_sqrt
  import epm_pkg::*;
#(
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [2*RW-1:0] in_x,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [RW-1:0]   out_root,
  output logic [SW-1:0]   out_side
);

  localparam int REMW = RW + 2;

  logic              vld_r  [RW+1];
  logic [2*RW-1:0]   x_r    [RW+1];
  logic [REMW-1:0]   rem_r  [RW+1];
  logic [RW-1:0]     root_r [RW+1];
  logic [SW-1:0]     side_r [RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    x_r[0]    <= in_x;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k <= RW; k++) begin : g_stage
    logic [REMW+1:0] sh;
    logic [REMW+1:0] trial;
    logic            ge;
    assign sh    = {rem_r[k-1], x_r[k-1][2*RW-1:2*RW-2]};
    assign trial = (REMW+2)'({root_r[k-1], 2'b01});
    assign ge    = (sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
      rem_r[k]  <= ge ? REMW'(sh - trial) : REMW'(sh);
      root_r[k] <= {root_r[k-1][RW-2:0], ge};
      x_r[k]    <= {x_r[k-1][2*RW-3:0], 2'b00};
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_vld  = vld_r[RW];
  assign out_root = root_r[RW];
  assign out_side = side_r[RW];

endmodule

// ----- tb/euler_primitive_and_mach_tb.sv -----
// Testbench for euler_primitive_and_mach: directed and random cells under several gammas,
// each result checked against a bit-exact predictor built in.
// Depends on epm_pkg and the euler_primitive_and_mach RTL.
module euler_primitive_and_mach_tb;
  import epm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  epm_in_t           in_data = '0;
  logic              out_valid;
  epm_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [GammaW-1:0] cfg_data = '0;

  localparam int LATENCY = 167;

  euler_primitive_and_mach dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [GammaW-1:0] gamma_now = GAMMA_RST;
  epm_out_t          pending_prims[$];
  int                mismatches = 0;
  bit                no_gaps = 1'b0;

  function automatic logic [31:0] clamp_s32(bit neg, bit [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] x);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic epm_out_t predict_primitive(epm_in_t c, logic [GammaW-1:0] gam);
    epm_out_t  r;
    bit [63:0] rho, ax, ay, en, g, s, q, ke, dmag, gmag, pmag, hi, lo, p, d, quot, rem;
    bit        nx, ny, dneg, gneg, pneg;
    rho = 64'(c.density);
    en = 64'(c.total_energy);
    g = 64'(gam);
    nx = c.momentum_x[31];
    ny = c.momentum_y[31];
    ax = nx ? 64'(-{32'd0, c.momentum_x}) & 64'hFFFF_FFFF : {32'd0, c.momentum_x};
    ay = ny ? 64'(-{32'd0, c.momentum_y}) & 64'hFFFF_FFFF : {32'd0, c.momentum_y};
    r = '0;
    r.density_out = c.density;
    r.last_out = c.last_cell;
    r.mach_number = MACH_MAX;
    r.status = STATUS_NONPOS;
    if (rho == 0) begin
      // no density: velocities pin to the momentum's sign
      r.velocity_x = (ax == 0) ? 32'd0 : clamp_s32(nx, 64'h8000_0000);
      r.velocity_y = (ay == 0) ? 32'd0 : clamp_s32(ny, 64'h8000_0000);
      return r;
    end
    r.velocity_x = clamp_s32(nx, (ax << 16) / rho);
    r.velocity_y = clamp_s32(ny, (ay << 16) / rho);
    s = ax * ax + ay * ay;
    q = s / rho;
    ke = q >> 1;
    dneg = ke > en;
    dmag = dneg ? ke - en : en - ke;
    gneg = g < 65536;
    gmag = gneg ? 65536 - g : g - 65536;
    pneg = dneg != gneg;
    hi = dmag >> 16;
    lo = dmag & 64'hFFFF;
    if (gmag == 0 || dmag == 0) pmag = 0;
    else if (hi >= (64'd1 << 32)) pmag = 64'd1 << 33;
    else pmag = hi * gmag + ((lo * gmag) >> 16);
    r.pressure = clamp_s32(pneg, pmag);
    if (!pneg && pmag != 0) begin
      p = (pmag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : pmag;
      d = g * p;
      r.status = STATUS_OK;
      if (d != 0 && q < (d << 14)) begin
        // q * 2^48 / d by restoring division
        quot = q / d;
        rem = q % d;
        for (int i = 0; i < 48; i++) begin
          rem <<= 1;
          quot <<= 1;
          if (rem >= d) begin
            rem -= d;
            quot |= 1;
          end
        end
        quot = int_sqrt(quot);
        r.mach_number = (quot > 64'h7FFF_FFFF) ? MACH_MAX : quot[30:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    epm_out_t want;
    if (rst_n && out_valid) begin
      if (pending_prims.size() == 0) begin
        report_mismatch("unexpected result", out_data.pressure, 32'd0);
      end else begin
        want = pending_prims.pop_front();
        if (out_data.density_out !== want.density_out)
          report_mismatch("density_out", 32'(out_data.density_out), 32'(want.density_out));
        if (out_data.velocity_x !== want.velocity_x)
          report_mismatch("velocity_x", out_data.velocity_x, want.velocity_x);
        if (out_data.velocity_y !== want.velocity_y)
          report_mismatch("velocity_y", out_data.velocity_y, want.velocity_y);
        if (out_data.pressure !== want.pressure)
          report_mismatch("pressure", out_data.pressure, want.pressure);
        if (out_data.mach_number !== want.mach_number)
          report_mismatch("mach_number", 32'(out_data.mach_number), 32'(want.mach_number));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.last_out !== want.last_out)
          report_mismatch("last_out", 32'(out_data.last_out), 32'(want.last_out));
      end
    end
  end

  // called at a falling edge; returns at a falling edge with start left high
  task automatic send_cell(epm_in_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = c;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pending_prims.push_back(predict_primitive(c, gamma_now));
    @(negedge clk);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_prims.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic set_gamma(logic [GammaW-1:0] v);
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    gamma_now = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic epm_in_t random_cell();
    epm_in_t c;
    logic [31:0] base;
    c.last_cell = $urandom_range(0, 7) == 0;
    if ($urandom_range(0, 4) == 0) begin
      c.density = 31'($urandom);
      c.momentum_x = $urandom;
      c.momentum_y = $urandom;
      c.total_energy = 31'($urandom);
    end else begin
      // physically plausible cell at a random scale
      c.density = 31'($urandom >> $urandom_range(1, 22)) | 31'd1;
      base = $urandom_range(8, 31);
      c.momentum_x = $signed($urandom) >>> base;
      c.momentum_y = $signed($urandom) >>> base;
      c.total_energy = 31'($urandom >> $urandom_range(1, 20));
    end
    return c;
  endfunction

  task automatic test_directed;
    epm_in_t c;
    logic [30:0] rhos[4] = '{31'd1, 31'h7FFF_FFFF, 31'd65536, 31'd0};
    logic [31:0] moms[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_0000};
    foreach (rhos[i]) begin
      foreach (moms[j]) begin
        c.density = rhos[i];
        c.momentum_x = moms[j];
        c.momentum_y = moms[(j + 1) % 4];
        c.total_energy = j[0] ? 31'h7FFF_FFFF : 31'd0;
        c.last_cell = j[1];
        send_cell(c);
      end
    end
    // still air at unit density and an energy of 2.5, then a mild subsonic flow
    c = '{31'd65536, 32'd0, 32'd0, 31'd163840, 1'b0};
    send_cell(c);
    c = '{31'd65536, 32'd32768, -32'sd16384, 31'd163840, 1'b1};
    send_cell(c);
    drain();
  endtask

  task automatic test_random_batch(int count);
    no_gaps = $urandom_range(0, 3) == 0;
    repeat (count) send_cell(random_cell());
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_gamma_sweep;
    logic [GammaW-1:0] gams[8] = '{18'd65537, 18'd196608, 18'd0, 18'd32768,
                                   18'd65536, 18'h3FFFF, 18'd91750, 18'd131072};
    foreach (gams[i]) begin
      set_gamma(gams[i]);
      test_directed();
      test_random_batch(60);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random_batch(100);
    test_gamma_sweep();
    drain();
    if (mismatches == 0) begin
      $display("PASS euler_primitive_and_mach");
    end else begin
      $display("FAIL euler_primitive_and_mach");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL euler_primitive_and_mach");
    $finish;
  end

endmodule

// ----- euler_primitive_and_mach.f -----
hw/rtl/epm_pkg.sv
hw/rtl/epm_div.sv
hw/rtl/epm_sqrt.sv
hw/rtl/euler_primitive_and_mach.sv
tb/euler_primitive_and_mach_tb.sv
